// ----- src/assert_macros.svh -----
// assertion macros shared by the decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define U8D_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// condition in one cycle implies a condition in the next cycle
`define U8D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/u8d_pkg.sv -----
// types, constants and tables of the utf-8 decoder
package u8d_pkg;

    localparam int INDEX_BITS   = 20;
    localparam int IDX_OUT_BITS = 20;
    localparam int CP_BITS      = 21;
    localparam int CLASS_BITS   = 4;
    localparam int STATE_BITS   = 4;
    localparam int NUM_STATES   = 9;
    localparam int NUM_CLASSES  = 12;
    localparam int Q_DEPTH      = 2;
    localparam int Q_PTR_BITS   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_BITS   = $clog2(Q_DEPTH + 1);

    typedef logic [CLASS_BITS-1:0] cls_t;
    typedef logic [STATE_BITS-1:0] state_t;
    typedef logic [INDEX_BITS-1:0] count_t;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam state_t ST_ACCEPT = 4'd0;
    localparam state_t ST_REJECT = 4'd1;

    localparam count_t CNT_MAX = '1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        cls_t       cls;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // next state by [state][class]
    localparam state_t NEXT_STATE [NUM_STATES][NUM_CLASSES] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1},
        '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
        '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
        '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
    };

    // byte class lookup
    function automatic cls_t byte_class(input logic [7:0] b);
        cls_t c;
        priority if (b < 8'h80) begin
            c = 4'd0;
        end else if (b < 8'h90) begin
            c = 4'd1;
        end else if (b < 8'hA0) begin
            c = 4'd9;
        end else if (b < 8'hC0) begin
            c = 4'd7;
        end else if (b < 8'hC2) begin
            c = 4'd8;
        end else if (b < 8'hE0) begin
            c = 4'd2;
        end else if (b == 8'hE0) begin
            c = 4'd10;
        end else if (b == 8'hED) begin
            c = 4'd4;
        end else if (b < 8'hF0) begin
            c = 4'd3;
        end else if (b == 8'hF0) begin
            c = 4'd11;
        end else if (b < 8'hF4) begin
            c = 4'd6;
        end else if (b == 8'hF4) begin
            c = 4'd5;
        end else begin
            c = 4'd8;
        end
        return c;
    endfunction

endpackage

// ----- src/u8d_front.sv -----
// front end: word acceptance and byte classification
module u8d_front
    import u8d_pkg::*;
(
    input  logic      s_valid,
    output logic      s_ready,
    input  logic      s_kind,
    input  logic [7:0] s_data_byte,
    input  q_status_t q_status,
    output logic      push,
    output item_t     push_item
);

    assign s_ready             = !q_status.full;
    assign push                = s_valid && !q_status.full;
    assign push_item.kind      = s_kind;
    assign push_item.data_byte = s_data_byte;
    assign push_item.cls       = byte_class(s_data_byte);

endmodule

// ----- src/u8d_queue.sv -----
// short queue of classified words between front and back
`include "assert_macros.svh"

module u8d_queue
    import u8d_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  item_t     push_item,
    input  logic      pop,
    output item_t     pop_item,
    output q_status_t q_status
);

    item_t                  slot_reg [Q_DEPTH];
    logic [Q_PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_BITS-1:0]  count_reg, count_next;

    assign q_status.full  = (count_reg == Q_CNT_BITS'(Q_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign pop_item       = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    `U8D_ASSERT(a_no_push_full, aclk, aresetn, !(push && q_status.full))
    `U8D_ASSERT(a_no_pop_empty, aclk, aresetn, !(pop && q_status.empty))

endmodule

// ----- src/u8d_back.sv -----
// back end: automaton step, code point accumulation, index count, result register
`include "assert_macros.svh"

module u8d_back
    import u8d_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  item_t                    pop_item,
    input  q_status_t                q_status,
    output logic                     pop,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_char_valid,
    output logic [CP_BITS-1:0]       m_codepoint,
    output logic [IDX_OUT_BITS-1:0]  m_char_index,
    output logic                     m_rejected,
    output logic                     m_end_report,
    output logic                     m_well_formed
);

    state_t                   dfa_state_reg, dfa_state_next;
    logic [CP_BITS-1:0]       acc_reg, acc_next;
    count_t                   cnt_reg, cnt_next;

    logic                     m_valid_reg, m_valid_next;
    logic                     char_valid_reg, char_valid_next;
    logic [CP_BITS-1:0]       codepoint_reg, codepoint_next;
    logic [IDX_OUT_BITS-1:0]  char_index_reg, char_index_next;
    logic                     rejected_reg, rejected_next;
    logic                     end_report_reg, end_report_next;
    logic                     well_formed_reg, well_formed_next;

    state_t                   cur_st;
    state_t                   nxt_st;
    logic [7:0]               lead_mask;

    logic                     end_pop;
    logic                     state_cleared;
    logic                     char_with_flag;

    assign pop = !q_status.empty && (!m_valid_reg || m_ready);

    always_comb begin
        cur_st    = (dfa_state_reg < STATE_BITS'(NUM_STATES)) ? dfa_state_reg : ST_REJECT;
        nxt_st    = NEXT_STATE[cur_st][pop_item.cls];
        lead_mask = 8'hFF >> pop_item.cls;

        dfa_state_next   = dfa_state_reg;
        acc_next         = acc_reg;
        cnt_next         = cnt_reg;
        char_valid_next  = 1'b0;
        codepoint_next   = '0;
        char_index_next  = '0;
        rejected_next    = 1'b0;
        end_report_next  = 1'b0;
        well_formed_next = 1'b0;

        if (pop_item.kind == KIND_END) begin
            char_index_next  = IDX_OUT_BITS'(cnt_reg);
            rejected_next    = (cur_st == ST_REJECT);
            end_report_next  = 1'b1;
            well_formed_next = (cur_st == ST_ACCEPT);
            dfa_state_next   = ST_ACCEPT;
            acc_next         = '0;
            cnt_next         = '0;
        end else begin
            if (cur_st != ST_ACCEPT) begin
                acc_next = {acc_reg[CP_BITS-7:0], pop_item.data_byte[5:0]};
            end else begin
                acc_next = CP_BITS'(lead_mask & pop_item.data_byte);
            end
            dfa_state_next = nxt_st;
            rejected_next  = (nxt_st == ST_REJECT);
            if (nxt_st == ST_ACCEPT) begin
                char_valid_next = 1'b1;
                codepoint_next  = acc_next;
                char_index_next = IDX_OUT_BITS'(cnt_reg);
                if (cnt_reg != CNT_MAX) begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
        end

        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dfa_state_reg <= ST_ACCEPT;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                dfa_state_reg <= dfa_state_next;
                acc_reg       <= acc_next;
                cnt_reg       <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            char_valid_reg  <= char_valid_next;
            codepoint_reg   <= codepoint_next;
            char_index_reg  <= char_index_next;
            rejected_reg    <= rejected_next;
            end_report_reg  <= end_report_next;
            well_formed_reg <= well_formed_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_char_valid  = char_valid_reg;
    assign m_codepoint   = codepoint_reg;
    assign m_char_index  = char_index_reg;
    assign m_rejected    = rejected_reg;
    assign m_end_report  = end_report_reg;
    assign m_well_formed = well_formed_reg;

    assign end_pop        = pop && (pop_item.kind == KIND_END);
    assign state_cleared  = (dfa_state_reg == ST_ACCEPT) && (cnt_reg == '0) && (acc_reg == '0);
    assign char_with_flag = m_valid_reg && char_valid_reg && (rejected_reg || end_report_reg);

    `U8D_ASSERT(a_state_in_range, aclk, aresetn, dfa_state_reg < STATE_BITS'(NUM_STATES))
    `U8D_ASSERT_NEXT(a_end_clears, aclk, aresetn, end_pop, state_cleared)
    `U8D_ASSERT(a_char_excl, aclk, aresetn, !char_with_flag)

endmodule

// ----- src/utf8_dfa_decoder_unit.sv -----
// top level of the utf-8 decoder
// Decodes a byte stream as UTF-8, one word per clock cycle sustained while m_ready is
// high. Each data word gives one result: char_valid and the code point with its
// character index when the byte completes a character, and rejected once the
// sequence is malformed (sticky until an end word). An end word reports the character
// count and whether the string was well formed, then restarts the decoder. A word is
// classified into the two-entry queue, then the automaton step writes its result into
// the result register; with m_ready low and a result held, words wait in the queue.
// The rate is set by that automaton step, which carries the state from byte to byte.
module utf8_dfa_decoder_unit
    import u8d_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_kind,
    input  logic [7:0]               s_data_byte,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_char_valid,
    output logic [CP_BITS-1:0]       m_codepoint,
    output logic [IDX_OUT_BITS-1:0]  m_char_index,
    output logic                     m_rejected,
    output logic                     m_end_report,
    output logic                     m_well_formed
);

    q_status_t q_status;
    logic      push;
    logic      pop;
    item_t     push_item;
    item_t     pop_item;

    u8d_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_data_byte (s_data_byte),
        .q_status    (q_status),
        .push        (push),
        .push_item   (push_item)
    );

    u8d_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_status  (q_status)
    );

    u8d_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_item      (pop_item),
        .q_status      (q_status),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_char_valid  (m_char_valid),
        .m_codepoint   (m_codepoint),
        .m_char_index  (m_char_index),
        .m_rejected    (m_rejected),
        .m_end_report  (m_end_report),
        .m_well_formed (m_well_formed)
    );

endmodule
